FILE: sv/lca_pkg.sv
// Shared constants and types for the life cellular automaton step block.
package lca_pkg;

    localparam int GRID_HEIGHT = 64;
    localparam int GRID_WIDTH  = 64;

    localparam int ROW_AW = $clog2(GRID_HEIGHT);
    localparam int COL_AW = $clog2(GRID_WIDTH);

    // Fixed field widths of one input word.
    localparam int KIND_W = 2;
    localparam int IDX_W  = 6;

    // APB register file: four registers at byte addresses 4*i.
    localparam int CFG_DW = 32;
    localparam int CFG_AW = 4;

    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

    localparam logic [1:0] REG_WRAP_EDGES  = 2'd0;
    localparam logic [1:0] REG_BIRTH_COUNT = 2'd1;
    localparam logic [1:0] REG_MIN_DEATH   = 2'd2;
    localparam logic [1:0] REG_MAX_DEATH   = 2'd3;

    typedef logic [GRID_WIDTH-1:0] row_t;
    typedef logic [3:0]            count_t;

endpackage

FILE: sv/lca_if.sv
// Valid/ready channel interfaces for input and result words.
interface lca_in_if;
    logic                            valid;
    logic                            ready;
    logic [lca_pkg::KIND_W-1:0]      kind;
    logic [lca_pkg::IDX_W-1:0]       row;
    logic [lca_pkg::IDX_W-1:0]       column;
    logic                            cell_in;

    modport source (output valid, kind, row, column, cell_in, input ready);
    modport sink   (input valid, kind, row, column, cell_in, output ready);
endinterface

interface lca_out_if;
    logic valid;
    logic ready;
    logic cell_out;
    logic generation_done;

    modport source (output valid, cell_out, generation_done, input ready);
    modport sink   (input valid, cell_out, generation_done, output ready);
endinterface

FILE: sv/lca_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lca_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/life_cellular_automaton_step.sv
// Life cellular automaton step: a grid of one-bit cells held in one row-wide RAM.
// Write and read words pass the cell state, then the done state, which loads the result
// register; unused kinds and cells outside the grid go straight to done. An advance word
// passes the top, first, run and end states: in run one RAM row per cycle enters a
// three-row window while one new row is written back. A waiting result holds the next done.
// Reset (rst_n low, async) kills all cells via per-row valid bits; rules go to 1, 3, 1, 4.
module life_cellular_automaton_step (
    input  logic                         clk,
    input  logic                         rst_n,
    lca_in_if.sink                       in_ch,
    lca_out_if.source                    out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lca_pkg::CFG_AW-1:0]   paddr,
    input  logic [lca_pkg::CFG_DW-1:0]   pwdata,
    output logic [lca_pkg::CFG_DW-1:0]   prdata,
    output logic                         pready
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_CELL      = 3'd1;
    localparam logic [2:0] S_GEN_TOP   = 3'd2;
    localparam logic [2:0] S_GEN_FIRST = 3'd3;
    localparam logic [2:0] S_GEN_RUN   = 3'd4;
    localparam logic [2:0] S_GEN_END   = 3'd5;
    localparam logic [2:0] S_DONE      = 3'd6;

    localparam logic [lca_pkg::ROW_AW-1:0] LAST_ROW =
        lca_pkg::ROW_AW'(lca_pkg::GRID_HEIGHT - 1);

    // Rule registers
    logic         wrap_reg;
    logic [3:0]   birth_reg;
    logic [3:0]   min_reg;
    logic [3:0]   max_reg;

    // Sequencer and result state
    logic [2:0]                     state_reg, state_next;
    logic [lca_pkg::ROW_AW-1:0]     gen_cnt_reg, gen_cnt_next;
    logic [lca_pkg::GRID_HEIGHT-1:0] row_valid_reg, row_valid_next;
    logic                           rd_valid_reg, rd_valid_next;
    logic                           res_cell_reg, res_cell_next;
    logic                           res_done_reg, res_done_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_cell_reg, out_cell_next;
    logic                           out_done_reg, out_done_next;

    // Item and row window payload
    logic [lca_pkg::KIND_W-1:0]     kind_reg;
    logic [lca_pkg::ROW_AW-1:0]     row_reg;
    logic [lca_pkg::COL_AW-1:0]     col_reg;
    logic                           cell_in_reg;
    lca_pkg::row_t                  above_reg, above_next;
    lca_pkg::row_t                  mid_reg, mid_next;
    lca_pkg::row_t                  first_reg, first_next;

    // RAM port
    logic                           ram_wr_en;
    logic [lca_pkg::ROW_AW-1:0]     ram_wr_addr;
    lca_pkg::row_t                  ram_wr_data;
    logic                           ram_rd_en;
    logic [lca_pkg::ROW_AW-1:0]     ram_rd_addr;
    lca_pkg::row_t                  ram_rd_data;

    logic                           in_accept;
    logic                           in_inside;
    logic                           out_free;
    logic                           cfg_write;
    lca_pkg::row_t                  rd_row;
    lca_pkg::row_t                  cell_row;
    lca_pkg::row_t                  gen_below;
    lca_pkg::row_t                  gen_row;

    // Pad a row with its wrap neighbours (or dead cells) at both ends.
    function automatic logic [lca_pkg::GRID_WIDTH+1:0] pad_row(
        input lca_pkg::row_t line,
        input logic          wrap
    );
        pad_row = {wrap & line[0], line, wrap & line[lca_pkg::GRID_WIDTH-1]};
    endfunction

    // Apply the rule to every column of one row at once.
    function automatic lca_pkg::row_t next_row(
        input lca_pkg::row_t above,
        input lca_pkg::row_t mid,
        input lca_pkg::row_t below,
        input logic          wrap,
        input logic [3:0]    birth,
        input logic [3:0]    min_d,
        input logic [3:0]    max_d
    );
        logic [lca_pkg::GRID_WIDTH+1:0] pa;
        logic [lca_pkg::GRID_WIDTH+1:0] pm;
        logic [lca_pkg::GRID_WIDTH+1:0] pb;
        lca_pkg::count_t                n;
        lca_pkg::row_t                  res;
        pa = pad_row(above, wrap);
        pm = pad_row(mid, wrap);
        pb = pad_row(below, wrap);
        res = '0;
        for (int c = 0; c < lca_pkg::GRID_WIDTH; c++)
        begin
            n = 4'(pa[c]) + 4'(pa[c+1]) + 4'(pa[c+2])
              + 4'(pm[c]) + 4'(pm[c+2])
              + 4'(pb[c]) + 4'(pb[c+1]) + 4'(pb[c+2]);
            if (!mid[c])
            begin
                res[c] = (n == birth);
            end
            else
            begin
                res[c] = !((n <= min_d) || (n >= max_d));
            end
        end
        next_row = res;
    endfunction

    lca_ram #(
        .WIDTH (lca_pkg::GRID_WIDTH),
        .DEPTH (lca_pkg::GRID_HEIGHT)
    ) u_grid (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // ---------------------------------------------------------------
    // APB rule registers: writes land in the access phase, pready tied high
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg  <= 1'b1;
            birth_reg <= 4'd3;
            min_reg   <= 4'd1;
            max_reg   <= 4'd4;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                lca_pkg::REG_WRAP_EDGES:  wrap_reg  <= pwdata[0];
                lca_pkg::REG_BIRTH_COUNT: birth_reg <= pwdata[3:0];
                lca_pkg::REG_MIN_DEATH:   min_reg   <= pwdata[3:0];
                lca_pkg::REG_MAX_DEATH:   max_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            lca_pkg::REG_WRAP_EDGES:  prdata = {31'd0, wrap_reg};
            lca_pkg::REG_BIRTH_COUNT: prdata = {28'd0, birth_reg};
            lca_pkg::REG_MIN_DEATH:   prdata = {28'd0, min_reg};
            lca_pkg::REG_MAX_DEATH:   prdata = {28'd0, max_reg};
            default:                  prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Handshake: take a word only in idle; the result register is separate,
    // so a waiting result never blocks taking the next word, only its done.
    // ---------------------------------------------------------------
    assign in_ch.ready            = (state_reg == S_IDLE);
    assign in_accept              = in_ch.valid & in_ch.ready;
    assign in_inside              = (int'(in_ch.row) < lca_pkg::GRID_HEIGHT)
                                  && (int'(in_ch.column) < lca_pkg::GRID_WIDTH);
    assign out_free               = !out_valid_reg || out_ch.ready;
    assign out_ch.valid           = out_valid_reg;
    assign out_ch.cell_out        = out_cell_reg;
    assign out_ch.generation_done = out_done_reg;

    // A row never written since reset reads as all dead.
    assign rd_row = rd_valid_reg ? ram_rd_data : '0;

    always_comb
    begin
        cell_row          = rd_row;
        cell_row[col_reg] = cell_in_reg;
    end

    // Bottom row sees the saved old row 0 (or dead cells) as its lower neighbour.
    assign gen_below = (state_reg == S_GEN_END) ? (wrap_reg ? first_reg : '0) : rd_row;
    assign gen_row   = next_row(above_reg, mid_reg, gen_below,
                                wrap_reg, birth_reg, min_reg, max_reg);

    // ---------------------------------------------------------------
    // Sequencer. An advance streams rows through the window:
    //   top   - old last row arrives, becomes the row above row 0
    //   first - old row 0 arrives, held as middle and saved for the bottom
    //   run   - row k arrives, write new row k-1, shift the window
    //   end   - write new last row
    // Reads always run two rows ahead of writes, so no entry is read after
    // it has been rewritten.
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        gen_cnt_next   = gen_cnt_reg;
        res_cell_next  = res_cell_reg;
        res_done_next  = res_done_reg;
        above_next     = above_reg;
        mid_next       = mid_reg;
        first_next     = first_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = lca_pkg::ROW_AW'(gen_cnt_reg + 1'b1);
        ram_wr_en      = 1'b0;
        ram_wr_addr    = lca_pkg::ROW_AW'(gen_cnt_reg - 1'b1);
        ram_wr_data    = gen_row;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_ch.kind == lca_pkg::KIND_ADVANCE)
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = LAST_ROW;
                        state_next  = S_GEN_TOP;
                    end
                    else if (((in_ch.kind == lca_pkg::KIND_WRITE)
                              || (in_ch.kind == lca_pkg::KIND_READ)) && in_inside)
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = lca_pkg::ROW_AW'(in_ch.row);
                        state_next  = S_CELL;
                    end
                    else
                    begin
                        // unused kind or cell outside the grid: no effect
                        res_cell_next = 1'b0;
                        res_done_next = 1'b0;
                        state_next    = S_DONE;
                    end
                end
            end
            S_CELL:
            begin
                if (kind_reg == lca_pkg::KIND_WRITE)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = row_reg;
                    ram_wr_data = cell_row;
                end
                res_cell_next = (kind_reg == lca_pkg::KIND_READ) ? rd_row[col_reg] : 1'b0;
                res_done_next = 1'b0;
                state_next    = S_DONE;
            end
            S_GEN_TOP:
            begin
                above_next  = wrap_reg ? rd_row : '0;
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                state_next  = S_GEN_FIRST;
            end
            S_GEN_FIRST:
            begin
                mid_next     = rd_row;
                first_next   = rd_row;
                ram_rd_en    = 1'b1;
                ram_rd_addr  = lca_pkg::ROW_AW'(1);
                gen_cnt_next = lca_pkg::ROW_AW'(1);
                state_next   = S_GEN_RUN;
            end
            S_GEN_RUN:
            begin
                ram_wr_en  = 1'b1;
                above_next = mid_reg;
                mid_next   = rd_row;
                if (gen_cnt_reg == LAST_ROW)
                begin
                    state_next = S_GEN_END;
                end
                else
                begin
                    ram_rd_en    = 1'b1;
                    gen_cnt_next = lca_pkg::ROW_AW'(gen_cnt_reg + 1'b1);
                end
            end
            S_GEN_END:
            begin
                ram_wr_en     = 1'b1;
                ram_wr_addr   = LAST_ROW;
                res_cell_next = 1'b0;
                res_done_next = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Valid bits: capture the bit of the row being read, set a bit on write.
    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (ram_wr_en)
        begin
            row_valid_next[ram_wr_addr] = 1'b1;
        end
        rd_valid_next = ram_rd_en ? row_valid_reg[ram_rd_addr] : rd_valid_reg;
    end

    // Result register: load from a finished word, drop when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_cell_next  = out_cell_reg;
        out_done_next  = out_done_reg;
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
            out_cell_next  = res_cell_reg;
            out_done_next  = res_done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gen_cnt_reg   <= '0;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            res_cell_reg  <= 1'b0;
            res_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_cell_reg  <= 1'b0;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_cnt_reg   <= gen_cnt_next;
            row_valid_reg <= row_valid_next;
            rd_valid_reg  <= rd_valid_next;
            res_cell_reg  <= res_cell_next;
            res_done_reg  <= res_done_next;
            out_valid_reg <= out_valid_next;
            out_cell_reg  <= out_cell_next;
            out_done_reg  <= out_done_next;
        end
    end

    // Payload: hold the accepted word and the row window.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg    <= in_ch.kind;
            row_reg     <= lca_pkg::ROW_AW'(in_ch.row);
            col_reg     <= lca_pkg::COL_AW'(in_ch.column);
            cell_in_reg <= in_ch.cell_in;
        end
        above_reg <= above_next;
        mid_reg   <= mid_next;
        first_reg <= first_next;
    end

`ifndef NO_ASSERTIONS
    // Generation writes trail reads, so the two ports never share a row.
    a_gen_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GEN_RUN) && ram_rd_en |-> (ram_rd_addr != ram_wr_addr))
        else $error("generation read and write hit the same row");

    // The final write of a generation happens only after the last row arrived.
    a_gen_end_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GEN_END) |-> (gen_cnt_reg == LAST_ROW))
        else $error("generation ended before the last row");

    // A finished word lands in the result register on the next edge.
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && out_free |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("finished word did not reach the result register");

    // A generation result always carries generation_done and no cell value.
    a_gen_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GEN_END) |=> res_done_reg && !res_cell_reg)
        else $error("generation result fields wrong");
`endif

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the life cellular automaton step block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // The block defines no name for the fourth kind; it must act as a no-op.
    localparam logic [lca_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int PHASE_WORDS  = 60;
    localparam int MAX_REPORTED = 10;
    localparam int SCRIPT_LEN   = 23;
    localparam int FIXED_RULES  = 7;
    localparam int RULE_SETS    = 10;

    typedef struct packed {
        logic [lca_pkg::KIND_W-1:0] kind;
        logic [lca_pkg::IDX_W-1:0]  row;
        logic [lca_pkg::IDX_W-1:0]  column;
        logic                       cell_in;
    } cell_cmd_t;

    typedef struct packed {
        logic cell_out;
        logic generation_done;
    } cell_reply_t;

    // One line of the opening script: a command word, and the reply when it is
    // obvious by inspection (known = 1); other lines rely on the grid model.
    typedef struct packed {
        cell_cmd_t   cmd;
        logic        known;
        cell_reply_t reply;
    } script_line_t;

    typedef struct packed {
        logic            wrap;
        lca_pkg::count_t birth;
        lca_pkg::count_t low_limit;
        lca_pkg::count_t high_limit;
    } rule_set_t;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [lca_pkg::CFG_AW-1:0]  paddr;
    logic [lca_pkg::CFG_DW-1:0]  pwdata;
    logic [lca_pkg::CFG_DW-1:0]  prdata;
    logic                        pready;

    lca_in_if  in_ch ();
    lca_out_if out_ch ();

    life_cellular_automaton_step DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Grid model and the rule registers as the block should hold them.
    lca_pkg::row_t   life_rows [lca_pkg::GRID_HEIGHT];
    logic            rule_wrap;
    lca_pkg::count_t rule_birth;
    lca_pkg::count_t rule_low;
    lca_pkg::count_t rule_high;

    // Replies owed by the block, oldest first.
    cell_reply_t awaited_replies [$];

    // Idling controls for the word feeder and the reply checker, and the word window.
    bit feed_stalls;
    bit reply_stalls;
    int win_row;
    int win_col;

    int mismatch_count;
    int replies_checked;
    int live_reads;
    int writes_sent;
    int reads_sent;
    int advances_sent;
    int unused_sent;
    int rule_sets_loaded;

    // Corners first, then a blinker straddling the wrap corner, then a lone
    // cell that must die of isolation.
    script_line_t opening_script [SCRIPT_LEN] = '{
        '{'{lca_pkg::KIND_READ,    6'd0,  6'd0,  1'b0}, 1'b1, '{1'b0, 1'b0}},
        '{'{lca_pkg::KIND_READ,    6'd63, 6'd63, 1'b1}, 1'b1, '{1'b0, 1'b0}},
        '{'{lca_pkg::KIND_WRITE,   6'd0,  6'd0,  1'b1}, 1'b1, '{1'b0, 1'b0}},
        '{'{lca_pkg::KIND_WRITE,   6'd63, 6'd63, 1'b1}, 1'b1, '{1'b0, 1'b0}},
        '{'{lca_pkg::KIND_READ,    6'd0,  6'd0,  1'b0}, 1'b1, '{1'b1, 1'b0}},
        '{'{lca_pkg::KIND_READ,    6'd63, 6'd63, 1'b0}, 1'b1, '{1'b1, 1'b0}},
        '{'{KIND_UNUSED,           6'd63, 6'd63, 1'b0}, 1'b1, '{1'b0, 1'b0}},
        '{'{lca_pkg::KIND_READ,    6'd63, 6'd63, 1'b0}, 1'b1, '{1'b1, 1'b0}},
        '{'{lca_pkg::KIND_WRITE,   6'd0,  6'd0,  1'b0}, 1'b1, '{1'b0, 1'b0}},
        '{'{lca_pkg::KIND_READ,    6'd0,  6'd0,  1'b1}, 1'b1, '{1'b0, 1'b0}},
        '{'{lca_pkg::KIND_WRITE,   6'd63, 6'd0,  1'b1}, 1'b1, '{1'b0, 1'b0}},
        '{'{lca_pkg::KIND_WRITE,   6'd63, 6'd1,  1'b1}, 1'b1, '{1'b0, 1'b0}},
        '{'{lca_pkg::KIND_ADVANCE, 6'd0,  6'd0,  1'b0}, 1'b1, '{1'b0, 1'b1}},
        '{'{lca_pkg::KIND_READ,    6'd62, 6'd0,  1'b0}, 1'b0, '{1'b0, 1'b0}},
        '{'{lca_pkg::KIND_READ,    6'd0,  6'd0,  1'b0}, 1'b0, '{1'b0, 1'b0}},
        '{'{lca_pkg::KIND_READ,    6'd63, 6'd63, 1'b0}, 1'b0, '{1'b0, 1'b0}},
        '{'{lca_pkg::KIND_ADVANCE, 6'd63, 6'd63, 1'b1}, 1'b1, '{1'b0, 1'b1}},
        '{'{lca_pkg::KIND_READ,    6'd63, 6'd1,  1'b0}, 1'b0, '{1'b0, 1'b0}},
        '{'{KIND_UNUSED,           6'd0,  6'd0,  1'b1}, 1'b1, '{1'b0, 1'b0}},
        '{'{lca_pkg::KIND_READ,    6'd0,  6'd0,  1'b0}, 1'b0, '{1'b0, 1'b0}},
        '{'{lca_pkg::KIND_WRITE,   6'd32, 6'd31, 1'b1}, 1'b1, '{1'b0, 1'b0}},
        '{'{lca_pkg::KIND_ADVANCE, 6'd21, 6'd42, 1'b0}, 1'b1, '{1'b0, 1'b1}},
        '{'{lca_pkg::KIND_READ,    6'd32, 6'd31, 1'b0}, 1'b0, '{1'b0, 1'b0}}
    };

    // Rule sets at the extremes: plain torus, bounded grid, birth on an empty
    // neighborhood, top counts, unreachable birth, bounds that kill all, and survival on 2 only.
    rule_set_t fixed_rules [FIXED_RULES] = '{
        '{1'b1, 4'd3,  4'd1,  4'd4},
        '{1'b0, 4'd3,  4'd1,  4'd4},
        '{1'b0, 4'd0,  4'd0,  4'd9},
        '{1'b1, 4'd8,  4'd8,  4'd9},
        '{1'b1, 4'd15, 4'd0,  4'd15},
        '{1'b0, 4'd2,  4'd15, 4'd0},
        '{1'b1, 4'd2,  4'd1,  4'd3}
    };

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hung handshake.
    initial
    begin : watchdog
        #(5_000_000);
        $display("tb: failure");
        $finish;
    end

    function automatic void log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
            $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    // Live cells among the left and right neighbors of column c in one row.
    function automatic lca_pkg::count_t side_pair(input lca_pkg::row_t line, input int c);
        lca_pkg::count_t n;
        n = '0;
        if (c > 0)
            n = n + lca_pkg::count_t'(line[c-1]);
        else if (rule_wrap)
            n = n + lca_pkg::count_t'(line[lca_pkg::GRID_WIDTH-1]);
        if (c < lca_pkg::GRID_WIDTH - 1)
            n = n + lca_pkg::count_t'(line[c+1]);
        else if (rule_wrap)
            n = n + lca_pkg::count_t'(line[0]);
        return n;
    endfunction

    // Advance the model grid one generation; every row reads the old grid.
    function automatic void step_generation();
        lca_pkg::row_t   old_rows [lca_pkg::GRID_HEIGHT];
        lca_pkg::row_t   above;
        lca_pkg::row_t   below;
        lca_pkg::row_t   fresh;
        lca_pkg::count_t n;
        old_rows = life_rows;
        for (int r = 0; r < lca_pkg::GRID_HEIGHT; r++)
        begin
            if (r > 0)
                above = old_rows[r-1];
            else
                above = rule_wrap ? old_rows[lca_pkg::GRID_HEIGHT-1] : '0;
            if (r < lca_pkg::GRID_HEIGHT - 1)
                below = old_rows[r+1];
            else
                below = rule_wrap ? old_rows[0] : '0;
            for (int c = 0; c < lca_pkg::GRID_WIDTH; c++)
            begin
                n = side_pair(above, c) + lca_pkg::count_t'(above[c]) + side_pair(below, c)
                    + lca_pkg::count_t'(below[c]) + side_pair(old_rows[r], c);
                if (!old_rows[r][c])
                    fresh[c] = (n == rule_birth);
                else
                    fresh[c] = !(n <= rule_low || n >= rule_high);
            end
            life_rows[r] = fresh;
        end
    endfunction

    // Apply one accepted word to the model and return the reply it owes.
    function automatic cell_reply_t apply_cell_command(input cell_cmd_t cmd);
        cell_reply_t reply;
        logic        in_grid;
        reply = '0;
        in_grid = (int'(cmd.row) < lca_pkg::GRID_HEIGHT)
                  && (int'(cmd.column) < lca_pkg::GRID_WIDTH);
        case (cmd.kind)
            lca_pkg::KIND_WRITE:
            begin
                writes_sent++;
                if (in_grid)
                    life_rows[cmd.row][cmd.column] = cmd.cell_in;
            end
            lca_pkg::KIND_READ:
            begin
                reads_sent++;
                if (in_grid)
                    reply.cell_out = life_rows[cmd.row][cmd.column];
            end
            lca_pkg::KIND_ADVANCE:
            begin
                advances_sent++;
                step_generation();
                reply.generation_done = 1'b1;
            end
            default:
                unused_sent++;
        endcase
        return reply;
    endfunction

    // Present one word after a random gap (when feed stalls are on) and hold it
    // until accepted. Valid stays high on return so a back-to-back word needs no second assignment.
    task automatic send_cmd(input cell_cmd_t cmd, input logic known,
                            input cell_reply_t typed_reply);
        int          gap;
        cell_reply_t modeled;
        gap = feed_stalls ? $urandom_range(0, 11) : 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= cmd.kind;
        in_ch.row     <= cmd.row;
        in_ch.column  <= cmd.column;
        in_ch.cell_in <= cmd.cell_in;
        do
            @(posedge clk);
        while (!in_ch.ready);
        modeled = apply_cell_command(cmd);
        awaited_replies.push_back(known ? typed_reply : modeled);
    endtask

    // Drop valid and hold until every owed reply has come back.
    task automatic wait_for_replies();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_replies.size() != 0);
    endtask

    // One APB write: setup cycle, access cycle, then the bus idles so the
    // next transfer starts in a fresh time step. Upper bits carry junk at
    // random; the register must keep only its own width.
    task automatic write_rule(input logic [1:0] reg_idx, input lca_pkg::count_t value);
        logic [lca_pkg::CFG_DW-1:0] word;
        int                         width;
        width = (reg_idx == lca_pkg::REG_WRAP_EDGES) ? 1 : 4;
        word = ($urandom_range(0, 1) != 0) ? (lca_pkg::CFG_DW'($urandom) << width) : '0;
        word = word | lca_pkg::CFG_DW'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lca_pkg::CFG_AW'({reg_idx, 2'b00});
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (reg_idx)
            lca_pkg::REG_WRAP_EDGES:  rule_wrap  = word[0];
            lca_pkg::REG_BIRTH_COUNT: rule_birth = word[3:0];
            lca_pkg::REG_MIN_DEATH:   rule_low   = word[3:0];
            lca_pkg::REG_MAX_DEATH:   rule_high  = word[3:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_rules(input rule_set_t rs);
        wait_for_replies();
        write_rule(lca_pkg::REG_WRAP_EDGES, lca_pkg::count_t'(rs.wrap));
        write_rule(lca_pkg::REG_BIRTH_COUNT, rs.birth);
        write_rule(lca_pkg::REG_MIN_DEATH, rs.low_limit);
        write_rule(lca_pkg::REG_MAX_DEATH, rs.high_limit);
        rule_sets_loaded++;
    endtask

    // Most words land in a 10x10 window so patterns can grow; the rest are
    // anywhere on the grid, including the no-op kind.
    function automatic cell_cmd_t random_cmd();
        cell_cmd_t cmd;
        int        pick;
        pick = $urandom_range(0, 99);
        cmd.row     = lca_pkg::IDX_W'(win_row + $urandom_range(0, 9));
        cmd.column  = lca_pkg::IDX_W'(win_col + $urandom_range(0, 9));
        cmd.cell_in = ($urandom_range(0, 9) < 7);
        if (pick < 45)
            cmd.kind = lca_pkg::KIND_WRITE;
        else if (pick < 75)
            cmd.kind = lca_pkg::KIND_READ;
        else if (pick < 85)
            cmd.kind = lca_pkg::KIND_ADVANCE;
        else
        begin
            cmd.row     = lca_pkg::IDX_W'($urandom);
            cmd.column  = lca_pkg::IDX_W'($urandom);
            cmd.cell_in = 1'($urandom);
            if (pick < 90)
                cmd.kind = KIND_UNUSED;
            else if (pick < 95)
                cmd.kind = lca_pkg::KIND_WRITE;
            else
                cmd.kind = lca_pkg::KIND_READ;
        end
        return cmd;
    endfunction

    // Reply side: stall at random when reply stalls are on, then compare each
    // accepted reply with the oldest owed one.
    initial
    begin : reply_checker
        int          stall;
        cell_reply_t got;
        cell_reply_t want;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = reply_stalls ? $urandom_range(0, 11) : 0;
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            got.cell_out        = out_ch.cell_out;
            got.generation_done = out_ch.generation_done;
            if (awaited_replies.size() == 0)
                log_mismatch("reply arrived with none owed");
            else
            begin
                want = awaited_replies.pop_front();
                replies_checked++;
                if (got.cell_out === 1'b1)
                    live_reads++;
                if (got.cell_out !== want.cell_out)
                    log_mismatch($sformatf("reply %0d cell_out expected %0b got %0b",
                                           replies_checked, want.cell_out, got.cell_out));
                if (got.generation_done !== want.generation_done)
                    log_mismatch($sformatf("reply %0d generation_done expected %0b got %0b",
                                           replies_checked, want.generation_done,
                                           got.generation_done));
            end
        end
    end

    initial
    begin : stimulus
        rule_set_t rs;
        int        mode;

        // Drive every input to a known value from time zero.
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.kind     <= lca_pkg::KIND_WRITE;
        in_ch.row      <= '0;
        in_ch.column   <= '0;
        in_ch.cell_in  <= 1'b0;

        // Model starts from the reset state: dead grid, standard rules.
        foreach (life_rows[r])
            life_rows[r] = '0;
        rule_wrap  = 1'b1;
        rule_birth = 4'd3;
        rule_low   = 4'd1;
        rule_high  = 4'd4;
        feed_stalls  = 1'b1;
        reply_stalls = 1'b1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the opening script under the reset rules.
        foreach (opening_script[i])
            send_cmd(opening_script[i].cmd, opening_script[i].known,
                     opening_script[i].reply);

        // Random phases, each under its own rule set and idling mix.
        for (int phase = 0; phase < RULE_SETS; phase++)
        begin
            if (phase < FIXED_RULES)
                rs = fixed_rules[phase];
            else
            begin
                rs.wrap       = 1'($urandom);
                rs.birth      = lca_pkg::count_t'($urandom);
                rs.low_limit  = lca_pkg::count_t'($urandom);
                rs.high_limit = lca_pkg::count_t'($urandom);
            end
            load_rules(rs);

            // First phase runs flat out, second idles on both sides.
            mode = (phase == 0) ? 0 : (phase == 1) ? 3 : $urandom_range(0, 3);
            feed_stalls  = mode[0];
            reply_stalls = mode[1];
            win_row = $urandom_range(0, lca_pkg::GRID_HEIGHT - 1);
            win_col = $urandom_range(0, lca_pkg::GRID_WIDTH - 1);

            repeat (PHASE_WORDS)
            begin
                send_cmd(random_cmd(), 1'b0, '0);
                // Now and then let the block drain completely mid-phase.
                if ($urandom_range(0, 39) == 0)
                    wait_for_replies();
            end
        end

        wait_for_replies();
        // Keep the clock running for any stray reply.
        repeat (lca_pkg::GRID_HEIGHT + 16) @(posedge clk);

        $display("covered %0d words: %0d writes, %0d reads, %0d generations, %0d no-ops",
                 writes_sent + reads_sent + advances_sent + unused_sent, writes_sent,
                 reads_sent, advances_sent, unused_sent);
        $display("%0d rule sets loaded, %0d replies checked, %0d live cells read back",
                 rule_sets_loaded, replies_checked, live_reads);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
